[hw/rtl/cfc_pkg.sv]
// Shared types and constants of the chunk framer.
package cfc_pkg;

  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned MAX_PAYLOAD = 4084;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_BYTES   = 8;
  localparam int unsigned HASH_BYTES  = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2941);

  localparam logic [1:0] KIND_NUMBER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_HASH    = 2'd2;

  // One classified payload byte, as passed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       open;
    logic       close;
  } entry_t;

endpackage

[hw/rtl/cfc_front.sv]
// Front end: accepts payload items and marks where chunks open and close.
module cfc_front #(
  parameter int unsigned MaxPayload = cfc_pkg::MAX_PAYLOAD
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cfc_pkg::SIZE_W-1:0] payload_size_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_input_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cfc_pkg::entry_t            q_entry_o
);
  import cfc_pkg::*;

  localparam int unsigned PW = $clog2(MaxPayload + 1);
  localparam int unsigned CW = (PW > SIZE_W) ? PW : SIZE_W;

  logic          in_chunk_q, in_chunk_d;
  logic [PW-1:0] count_q, count_d;
  logic [PW-1:0] count_new;
  logic [CW-1:0] size_raw;
  logic [CW-1:0] size_eff;
  logic          close;
  logic          accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A size of zero acts as one; anything above the maximum is clamped.
  assign size_raw = CW'(payload_size_i);
  always_comb begin
    if (size_raw == '0) begin
      size_eff = CW'(1);
    end else if (size_raw > CW'(MaxPayload)) begin
      size_eff = CW'(MaxPayload);
    end else begin
      size_eff = size_raw;
    end
  end

  assign count_new = in_chunk_q ? count_q + PW'(1) : PW'(1);
  assign close     = end_of_input_i || (CW'(count_new) >= size_eff);

  assign q_push_o        = accept;
  assign q_entry_o.data  = data_byte_i;
  assign q_entry_o.open  = !in_chunk_q;
  assign q_entry_o.close = close;

  always_comb begin
    in_chunk_d = in_chunk_q;
    count_d    = count_q;
    if (accept) begin
      in_chunk_d = !close;
      count_d    = close ? '0 : count_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chunk_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_chunk_q <= in_chunk_d;
      count_q    <= count_d;
    end
  end

endmodule

[hw/rtl/cfc_fifo.sv]
// Short queue of classified items between the front and the back.
module cfc_fifo #(
  parameter int unsigned Depth = cfc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cfc_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            nempty_o,
  output cfc_pkg::entry_t rdata_o
);
  import cfc_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  entry_t        mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign full_o   = (cnt_q == NW'(Depth));
  assign nempty_o = (cnt_q != '0);
  assign rdata_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/cfc_back.sv]
// Back end: emits number, payload and hash bytes and keeps the running hash.
module cfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_nempty_i,
  input  cfc_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      byte_kind_o,
  output logic            chunk_last_o
);
  import cfc_pkg::*;

  localparam logic [1:0] PH_NUM  = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_HASH = 2'd2;

  logic [1:0]  ph_q, ph_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] cn_q, cn_d;
  logic [31:0] part_q, part_d;
  logic [31:0] pow_q, pow_d;
  logic [31:0] cp_q, cp_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic [1:0]  ok_q, ok_d;
  logic        ol_q, ol_d;

  logic        adv;
  logic        fold;
  logic [7:0]  fold_byte;
  logic [7:0]  num_byte;
  logic [31:0] hash;
  logic [31:0] cp_sum;

  assign adv      = q_nempty_i && (!ov_q || out_ready_i);
  assign num_byte = cn_q[{idx_q, 3'b000} +: 8];
  // The seeded hash is count*5^n plus the unseeded sum; count*5^n is kept in cp.
  assign hash     = cp_q + part_q;
  assign cp_sum   = cp_q + pow_q;

  always_comb begin
    ph_d      = ph_q;
    idx_d     = idx_q;
    cn_d      = cn_q;
    ov_d      = ov_q && !out_ready_i;
    ob_d      = ob_q;
    ok_d      = ok_q;
    ol_d      = ol_q;
    q_pop_o   = 1'b0;
    fold      = 1'b0;
    fold_byte = q_entry_i.data;
    if (adv) begin
      ov_d = 1'b1;
      ol_d = 1'b0;
      case (ph_q)
        PH_NUM, PH_PAY: begin
          if (ph_q == PH_NUM && q_entry_i.open) begin
            fold_byte = num_byte;
            fold      = 1'b1;
            ob_d      = num_byte;
            ok_d      = KIND_NUMBER;
            idx_d     = idx_q + 3'd1;
            if (idx_q == 3'(NUM_BYTES - 1)) begin
              ph_d  = PH_PAY;
              idx_d = '0;
            end
          end else begin
            fold = 1'b1;
            ob_d = q_entry_i.data;
            ok_d = KIND_PAYLOAD;
            if (q_entry_i.close) begin
              ph_d  = PH_HASH;
              idx_d = '0;
            end else begin
              ph_d    = PH_NUM;
              q_pop_o = 1'b1;
            end
          end
        end
        PH_HASH: begin
          ob_d  = hash[{idx_q[1:0], 3'b000} +: 8];
          ok_d  = KIND_HASH;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(HASH_BYTES - 1)) begin
            ol_d    = 1'b1;
            ph_d    = PH_NUM;
            idx_d   = '0;
            cn_d    = cn_q + 64'd1;
            q_pop_o = 1'b1;
          end
        end
        default: begin
          ph_d  = PH_NUM;
          idx_d = '0;
        end
      endcase
    end
  end

  // Per hashed byte: sum = 5*sum + b, pow = 5*pow, cp = 5*(cp + pow).
  always_comb begin
    part_d = part_q;
    pow_d  = pow_q;
    cp_d   = cp_q;
    if (fold) begin
      part_d = (part_q << 2) + part_q + 32'(fold_byte);
      pow_d  = (pow_q << 2) + pow_q;
      cp_d   = (cp_sum << 2) + cp_sum;
    end else if (adv && ph_q == PH_HASH && idx_q == 3'(HASH_BYTES - 1)) begin
      part_d = '0;
      pow_d  = 32'd1;
      cp_d   = '0;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign byte_kind_o  = ok_q;
  assign chunk_last_o = ol_q;

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ok_q <= ok_d;
    ol_q <= ol_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_NUM;
      idx_q  <= '0;
      cn_q   <= '0;
      part_q <= '0;
      pow_q  <= 32'd1;
      cp_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      idx_q  <= idx_d;
      cn_q   <= cn_d;
      part_q <= part_d;
      pow_q  <= pow_d;
      cp_q   <= cp_d;
      ov_q   <= ov_d;
    end
  end

endmodule

[hw/rtl/chunk_framer_counter_hash.sv]
// Top level of the chunk framer with chunk counter and multiply-by-five hash.
//
// Payload bytes enter on the input channel (in_valid_i, in_ready_o, data_byte_i,
// end_of_input_i), one item per accepted handshake. Framed bytes leave on the
// output channel (out_valid_o, out_ready_i, out_byte_o, byte_kind_o,
// chunk_last_o). Each chunk is its 8-byte little-endian number, its payload and
// a 4-byte little-endian hash; chunk_last_o marks the final hash byte.
// The front end classifies each input item (opens a chunk, closes a chunk) and
// writes it into a short queue; the back end expands queue items into output
// bytes and folds every number and payload byte into the hash.
// The input side takes one item per cycle while the queue has room. The back
// end emits one output byte per cycle while an item is queued and the output
// register is empty or being read. An opening item adds eight number bytes ahead,
// a closing one four hash bytes after; the queue feeds the output register.
// When the receiver stalls, the output register holds its byte, the back end
// stops, and the input side keeps accepting until the queue is full.
// Reset clears the chunk number to zero, closes any open chunk, empties the
// queue and restores payload_size to its reset value of 2941. Users must write
// the size through payload_size_we_i only while the block is idle; unenforced.
module chunk_framer_counter_hash #(
  parameter int unsigned MaxPayload = cfc_pkg::MAX_PAYLOAD,
  parameter int unsigned QueueDepth = cfc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       payload_size_we_i,
  input  logic [cfc_pkg::SIZE_W-1:0] payload_size_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_input_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [1:0]                 byte_kind_o,
  output logic                       chunk_last_o
);
  import cfc_pkg::*;

  logic [SIZE_W-1:0] size_q;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_nempty;
  entry_t            q_wdata;
  entry_t            q_rdata;

  // The size register; users must write it only with no item in flight (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (payload_size_we_i) begin
      size_q <= payload_size_i;
    end
  end

  cfc_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .payload_size_i(size_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_input_i(end_of_input_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wdata)
  );

  cfc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .nempty_o(q_nempty),
    .rdata_o (q_rdata)
  );

  cfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nempty_i  (q_nempty),
    .q_entry_i   (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .byte_kind_o (byte_kind_o),
    .chunk_last_o(chunk_last_o)
  );

  // The closing flag only ever sits on the final hash byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_last_o |-> byte_kind_o == KIND_HASH)
    else $error("chunk_last on a byte that is not a hash byte");

  // After a chunk has closed, the next byte out starts a new chunk number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && chunk_last_o |=>
      !out_valid_o || byte_kind_o == KIND_NUMBER)
    else $error("chunk did not start with its number");

  // Number bytes never follow a payload byte directly: a hash must come first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && byte_kind_o == KIND_PAYLOAD |=>
      !out_valid_o || byte_kind_o != KIND_NUMBER)
    else $error("chunk number emitted inside an open chunk");

  // A payload byte is never taken in while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the chunk framer with chunk counter and hash.
//
// Every payload item offered to the block is run through a predictor that
// keeps its own chunk number, hash state and payload size. The predictor
// queues the framed bytes that the item should produce. A separate process
// takes each byte from the output channel and compares it, field by field,
// with the oldest byte in that queue. The stimulus is a handful of directed
// tests, then a long random stream over several payload sizes, then a stretch
// in which the receiver holds off long enough for the block to fill up and
// stall its input. The sender idles in bursts and the receiver stalls on a
// pattern of its own, so gaps fall at every point in a chunk.
module tb_top;
  import cfc_pkg::*;

  // A cycle limit without any handshake on either side. It is far beyond the
  // longest correct quiet stretch, which is the deliberate output hold.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned REPORT_CAP  = 50;

  // One framed byte as it should appear on the output channel.
  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       last;
  } framed_byte_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              size_we = 1'b0;
  logic [SIZE_W-1:0] size_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_byte = '0;
  logic              in_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_byte;
  logic [1:0]        byte_kind;
  logic              chunk_last;

  // Predictor state: the running chunk and the payload size as last written.
  logic [63:0]       chunk_no;
  logic [31:0]       frame_sum;
  logic [31:0]       frame_pow;
  logic [12:0]       frame_len;
  logic              chunk_open;
  logic [SIZE_W-1:0] size_reg;

  framed_byte_t      framed_q[$];

  int unsigned       error_count;
  int unsigned       items_sent;
  int unsigned       bytes_checked;
  int unsigned       chunks_closed;
  int unsigned       input_stalls;
  int unsigned       burst_left;
  bit                no_gaps;
  int unsigned       hold_req;

  chunk_framer_counter_hash dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .payload_size_we_i (size_we),
    .payload_size_i    (size_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (in_byte),
    .end_of_input_i    (in_end),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_byte_o        (out_byte),
    .byte_kind_o       (byte_kind),
    .chunk_last_o      (chunk_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts it. Printing stops after a cap so
  // that a badly broken block cannot flood the log, but counting carries on.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h (byte %0d)",
               $time, what, got, want, bytes_checked);
    end
  endtask

  // Folds one number or payload byte into the hash. The seed is the byte
  // count, which is only known at the close, so the sum is kept unseeded
  // together with 5^n and the seed is added in as count * 5^n at the end.
  function automatic void fold_into_hash(input logic [7:0] b);
    frame_sum = frame_sum * 32'd5 + {24'd0, b};
    frame_pow = frame_pow * 32'd5;
    frame_len = frame_len + 13'd1;
  endfunction

  // Works out every framed byte caused by one payload item and queues them.
  function automatic void predict_framing(input logic [7:0] value,
                                          input logic closes_early);
    int unsigned eff_size;
    int unsigned payload_seen;
    logic [31:0] hash;
    logic [7:0]  nb;

    eff_size = size_reg;
    if (eff_size < 1) eff_size = 1;
    if (eff_size > MAX_PAYLOAD) eff_size = MAX_PAYLOAD;

    // The first byte of a chunk is preceded by the little-endian number.
    if (!chunk_open) begin
      frame_sum  = '0;
      frame_pow  = 32'd1;
      frame_len  = '0;
      chunk_open = 1'b1;
      for (int i = 0; i < NUM_BYTES; i++) begin
        nb = chunk_no[8*i +: 8];
        fold_into_hash(nb);
        framed_q.push_back('{value: nb, kind: KIND_NUMBER, last: 1'b0});
      end
    end

    fold_into_hash(value);
    framed_q.push_back('{value: value, kind: KIND_PAYLOAD, last: 1'b0});

    // A size lowered below the bytes already taken closes on this byte too,
    // hence the comparison is greater-or-equal rather than equality.
    payload_seen = (frame_len >= NUM_BYTES) ? frame_len - NUM_BYTES : 0;
    if (closes_early || payload_seen >= eff_size) begin
      hash = {19'd0, frame_len} * frame_pow + frame_sum;
      for (int i = 0; i < HASH_BYTES; i++) begin
        framed_q.push_back('{value: hash[8*i +: 8], kind: KIND_HASH,
                             last: (i == HASH_BYTES - 1)});
      end
      chunk_no   = chunk_no + 64'd1;
      frame_sum  = '0;
      frame_pow  = 32'd1;
      frame_len  = '0;
      chunk_open = 1'b0;
      chunks_closed++;
    end
  endfunction

  // Offers one payload item and returns at the edge where it is taken. The
  // valid is left high on return; the next call either replaces the payload
  // in the same step or lowers valid for a gap, never both.
  task automatic send_item(input logic [7:0] value, input logic closes_early);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    predict_framing(value, closes_early);
    in_valid <= 1'b1;
    in_byte  <= value;
    in_end   <= closes_early;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted byte has come out, then lets
  // the short pipeline settle.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle. A chunk may still be
  // open across the write, which is how a mid-chunk size change is reached.
  task automatic write_payload_size(input logic [SIZE_W-1:0] value);
    wait_for_quiet();
    size_we   <= 1'b1;
    size_data <= value;
    @(posedge clk_i);
    size_we  <= 1'b0;
    size_reg = value;
  endtask

  // The reset size of 2941 never closes a chunk on count here, so the chunks
  // end on the end flag alone, including one with a single payload item.
  task automatic test_default_size();
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'ha5, 1'b1);
  endtask

  // Size zero behaves as one, and anything above the maximum as the maximum.
  task automatic test_size_limits();
    write_payload_size('0);
    send_item(8'h5a, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    write_payload_size('1);
    send_item(8'h81, 1'b0);
    send_item(8'h7e, 1'b0);
    send_item(8'h3c, 1'b1);
    write_payload_size(SIZE_W'(MAX_PAYLOAD));
    send_item(8'hc3, 1'b0);
    send_item(8'h18, 1'b1);
    write_payload_size(SIZE_W'(1));
    send_item(8'hfe, 1'b0);
    send_item(8'h01, 1'b0);
  endtask

  // Five items go into a chunk of ten, then the size drops to three with the
  // chunk still open, so the very next item must close it.
  task automatic test_size_lowered();
    write_payload_size(SIZE_W'(10));
    for (int i = 0; i < 5; i++) send_item(8'(8'h10 + i), 1'b0);
    write_payload_size(SIZE_W'(3));
    send_item(8'h99, 1'b0);
  endtask

  // A chunk that fills to exactly the size, then one cut short by the flag.
  task automatic test_exact_fill();
    write_payload_size(SIZE_W'(4));
    for (int i = 0; i < 4; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'haa, 1'b1);
  endtask

  // Random bytes over a spread of sizes, both limits and the clamps included.
  // Larger sizes get the end flag more often so that chunks still close.
  task automatic test_random_stream();
    int unsigned sizes[9];
    logic [7:0]  value;
    logic        flag;
    sizes = '{1, 2, 3, 5, 7, 16, 0, 4095, 0};
    sizes[8] = $urandom_range(1, 40);
    foreach (sizes[p]) begin
      write_payload_size(SIZE_W'(sizes[p]));
      for (int i = 0; i < 18; i++) begin
        case ($urandom_range(0, 9))
          0:       value = 8'h00;
          1:       value = 8'hff;
          default: value = 8'($urandom_range(0, 255));
        endcase
        if (sizes[p] >= 16 || sizes[p] == 0) begin
          flag = ($urandom_range(0, 4) == 0);
        end else begin
          flag = ($urandom_range(0, 7) == 0);
        end
        send_item(value, flag);
      end
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming with
  // no gaps, so the internal queue fills and the input side has to stall.
  task automatic test_output_hold();
    write_payload_size(SIZE_W'(6));
    hold_req = HOLD_CYCLES;
    no_gaps  = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: a stall pattern that changes every so often between always
  // ready, half the time, rarely, and on a regular beat from a tick counter. A
  // hold request from a test overrides it for a counted number of cycles.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Output checker: each byte taken from the block is compared with the
  // oldest prediction. A byte with nothing waiting is an error on its own.
  always @(posedge clk_i) begin : check_output
    framed_byte_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (framed_q.size() == 0) begin
        report_mismatch("unexpected byte", {24'd0, out_byte}, 32'd0);
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.value) begin
          report_mismatch("out_byte", {24'd0, out_byte}, {24'd0, want.value});
        end
        if (byte_kind !== want.kind) begin
          report_mismatch("byte_kind", {30'd0, byte_kind}, {30'd0, want.kind});
        end
        if (chunk_last !== want.last) begin
          report_mismatch("chunk_last", {31'd0, chunk_last}, {31'd0, want.last});
        end
      end
      bytes_checked++;
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item or a byte,
  // and also tallies input stall cycles for the summary.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else begin
      if (in_valid && in_ready !== 1'b1) input_stalls++;
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("TIMEOUT at %0t: no handshake for %0d cycles, %0d bytes pending",
                 $time, quiet, framed_q.size());
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin : main
    chunk_no      = '0;
    frame_sum     = '0;
    frame_pow     = 32'd1;
    frame_len     = '0;
    chunk_open    = 1'b0;
    size_reg      = SIZE_RESET;
    error_count   = 0;
    items_sent    = 0;
    bytes_checked = 0;
    chunks_closed = 0;
    input_stalls  = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    hold_req      = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_size();
    test_size_limits();
    test_size_lowered();
    test_exact_fill();
    test_random_stream();
    test_output_hold();

    // Let everything drain, then watch a little longer for stray bytes.
    wait_for_quiet();
    repeat (20) @(posedge clk_i);
    if (framed_q.size() != 0) begin
      report_mismatch("bytes never seen", framed_q.size(), 32'd0);
    end

    $display("Sent %0d payload items, checked %0d framed bytes over %0d chunks.",
             items_sent, bytes_checked, chunks_closed);
    $display("Sizes from 0 to 4095 written; input stalled for %0d cycles.",
             input_stalls);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
